### hw/rtl/msps_pkg.sv
// shared types and constants for the shortest path search block
`default_nettype none

package msps_pkg;

    localparam int DEFAULT_MAX_VERTICES = 16;
    localparam int DEFAULT_WEIGHT_BITS  = 16;

    localparam int DIST_W      = 31;
    localparam int VCOUNT_W    = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int VTX_OUT_W   = 4;

    localparam logic [DIST_W-1:0]   DIST_INF   = {DIST_W{1'b1}};
    localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 5'd16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CHECK_W,
        S_INIT,
        S_PICK,
        S_PICK_W,
        S_DECIDE,
        S_RELAX,
        S_RELAX_W,
        S_OUT,
        S_OUT_LD,
        S_ERR
    } t_state;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_NEG   = 2'd3
    } t_status;

    typedef enum logic {
        OP_PICK,
        OP_RELAX
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [DIST_W-1:0]  a;
        logic signed [DIST_W:0] addend;
        logic [DIST_W-1:0]  b;
    } t_alu_req;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] sum;
    } t_alu_res;

endpackage

`default_nettype wire

### hw/rtl/matrix_shortest_path_search_core.sv
// single-source shortest path search over a stored adjacency matrix
// a search runs a negative weight scan, an init pass, the relax rounds and then the
//   result beats, one per vertex
// one beat at a time, s_tready low while a search runs; a failed check gives its
//   one beat; output stalls hold the result beats
// reset: synchronous active low; the weight matrix is then swept to zero with
//   s_tready low
`default_nettype none

module matrix_shortest_path_search_core #(
    parameter int MAX_VERTICES = msps_pkg::DEFAULT_MAX_VERTICES,
    parameter int WEIGHT_BITS  = msps_pkg::DEFAULT_WEIGHT_BITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // input stream
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    // edge_row[3:0], edge_col[7:4], arc_weight[23:8], source_vertex[27:24]
    input  wire  [msps_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // kind[0]
    input  wire                                 i_s_tuser,
    // result stream
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    // vertex[3:0], distance[34:4]
    output logic [msps_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // status[1:0]
    output logic [1:0]                          o_m_tuser,
    output logic                                o_m_tlast,
    // vertex_count write channel
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [msps_pkg::VCOUNT_W-1:0]       i_cfg_data
);

    localparam int VB = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = 2 * VB;
    localparam int DW = msps_pkg::DIST_W;

    // input fields
    logic                       w_kind;
    logic [3:0]                 w_edge_row;
    logic [3:0]                 w_edge_col;
    logic signed [15:0]         w_arc_weight;
    logic [3:0]                 w_source_vertex;
    logic                       w_acc;

    assign w_kind          = i_s_tuser;
    assign w_edge_row      = i_s_tdata[3:0];
    assign w_edge_col      = i_s_tdata[7:4];
    assign w_arc_weight    = i_s_tdata[23:8];
    assign w_source_vertex = i_s_tdata[27:24];
    assign w_acc           = i_s_tvalid && o_s_tready;

    // sequencer state
    msps_pkg::t_state           r_state, n_state;
    logic [msps_pkg::VCOUNT_W-1:0] r_vcount;
    logic [CW-1:0]              w_n;
    logic [CW-1:0]              w_nm1;
    logic [VB-1:0]              r_src;
    msps_pkg::t_status          r_err;
    logic [CW-1:0]              r_row;
    logic [CW-1:0]              r_col;
    logic                       w_col_last;
    logic                       w_row_last;
    logic                       r_rv;
    logic [VB-1:0]              r_ridx;
    logic [DW-1:0]              r_best_d;
    logic [VB-1:0]              r_best_v;
    logic [MAX_VERTICES-1:0]    r_settled;
    logic [CW-1:0]              r_round;

    // output register
    logic                       r_ovalid;
    logic [msps_pkg::VTX_OUT_W-1:0] r_ovtx;
    logic [DW-1:0]              r_odist;
    msps_pkg::t_status          r_ostat;
    logic                       r_olast;
    logic                       w_out_free;

    // memory and unit hookup
    logic                       w_wm_we;
    logic [AW-1:0]              w_wm_waddr;
    logic [AW-1:0]              w_wm_raddr;
    logic signed [WEIGHT_BITS-1:0] w_wm_rdata;
    logic                       w_wm_busy;
    logic                       w_rd_neg;
    logic                       w_load_ok;
    logic                       w_dm_we;
    logic [VB-1:0]              w_dm_waddr;
    logic [DW-1:0]              w_dm_wdata;
    logic [DW-1:0]              w_dm_rdata;
    msps_pkg::t_alu_req         w_req;
    msps_pkg::t_alu_res         w_res;
    logic                       w_take;

    // active vertex count, saturated to the matrix size
    always_comb begin
        if (32'(r_vcount) > 32'(MAX_VERTICES)) begin
            w_n = CW'(MAX_VERTICES);
        end else begin
            w_n = CW'(r_vcount);
        end
    end

    assign w_nm1      = w_n - 1'b1;
    assign w_col_last = (r_col == w_nm1);
    assign w_row_last = (r_row == w_nm1);
    assign w_out_free = !r_ovalid || i_m_tready;
    assign w_rd_neg   = r_rv && w_wm_rdata[WEIGHT_BITS-1];
    assign w_load_ok  = (32'(w_edge_row) < 32'(MAX_VERTICES))
                        && (32'(w_edge_col) < 32'(MAX_VERTICES));
    // a relax or pick hit only counts for an unsettled vertex
    assign w_take     = r_rv && w_res.hit && !r_settled[r_ridx];

    assign o_cfg_ready = 1'b1;

    msps_wmem #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .ADDR_W      (AW)
    ) u_wmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_wm_we),
        .i_waddr (w_wm_waddr),
        .i_wdata (WEIGHT_BITS'(w_arc_weight)),
        .i_raddr (w_wm_raddr),
        .o_rdata (w_wm_rdata),
        .o_busy  (w_wm_busy)
    );

    msps_dist_mem #(
        .ADDR_W (VB)
    ) u_dist_mem (
        .i_clk   (i_clk),
        .i_we    (w_dm_we),
        .i_waddr (w_dm_waddr),
        .i_wdata (w_dm_wdata),
        .i_raddr (r_col[VB-1:0]),
        .o_rdata (w_dm_rdata)
    );

    msps_alu u_alu (
        .i_req (w_req),
        .o_res (w_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msps_pkg::S_IDLE: begin
                if (w_acc && w_kind) begin
                    if (w_n == '0) begin
                        n_state = msps_pkg::S_ERR;
                    end else if (32'(w_source_vertex) >= 32'(w_n)) begin
                        n_state = msps_pkg::S_ERR;
                    end else begin
                        n_state = msps_pkg::S_CHECK;
                    end
                end
            end
            msps_pkg::S_CHECK: begin
                if (w_rd_neg) begin
                    n_state = msps_pkg::S_ERR;
                end else if (w_row_last && w_col_last) begin
                    n_state = msps_pkg::S_CHECK_W;
                end
            end
            msps_pkg::S_CHECK_W: begin
                n_state = w_rd_neg ? msps_pkg::S_ERR : msps_pkg::S_INIT;
            end
            msps_pkg::S_INIT: begin
                if (w_col_last) begin
                    // a single vertex needs no rounds
                    n_state = (w_nm1 == '0) ? msps_pkg::S_OUT : msps_pkg::S_PICK;
                end
            end
            msps_pkg::S_PICK: begin
                if (w_col_last) begin
                    n_state = msps_pkg::S_PICK_W;
                end
            end
            msps_pkg::S_PICK_W: begin
                n_state = msps_pkg::S_DECIDE;
            end
            msps_pkg::S_DECIDE: begin
                // nearest open vertex unreachable: search is over
                if (r_best_d == msps_pkg::DIST_INF) begin
                    n_state = msps_pkg::S_OUT;
                end else begin
                    n_state = msps_pkg::S_RELAX;
                end
            end
            msps_pkg::S_RELAX: begin
                if (w_col_last) begin
                    n_state = msps_pkg::S_RELAX_W;
                end
            end
            msps_pkg::S_RELAX_W: begin
                if ((r_round + 1'b1) == w_nm1) begin
                    n_state = msps_pkg::S_OUT;
                end else begin
                    n_state = msps_pkg::S_PICK;
                end
            end
            msps_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = msps_pkg::S_OUT_LD;
                end
            end
            msps_pkg::S_OUT_LD: begin
                n_state = w_col_last ? msps_pkg::S_IDLE : msps_pkg::S_OUT;
            end
            msps_pkg::S_ERR: begin
                if (w_out_free) begin
                    n_state = msps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = msps_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer outputs: handshake, memory ports, shared unit operands
    always_comb begin
        o_s_tready  = 1'b0;
        w_wm_we     = 1'b0;
        w_wm_waddr  = {VB'(w_edge_row), VB'(w_edge_col)};
        w_wm_raddr  = {r_best_v, r_col[VB-1:0]};
        w_dm_we     = 1'b0;
        w_dm_waddr  = r_ridx;
        w_dm_wdata  = w_res.sum;
        w_req.op     = msps_pkg::OP_PICK;
        w_req.a      = w_dm_rdata;
        w_req.addend = '0;
        w_req.b      = r_best_d;
        unique case (r_state) inside
            msps_pkg::S_IDLE: begin
                o_s_tready = !w_wm_busy;
                w_wm_we    = w_acc && !w_kind && w_load_ok;
            end
            msps_pkg::S_CHECK: begin
                w_wm_raddr = {r_row[VB-1:0], r_col[VB-1:0]};
            end
            msps_pkg::S_INIT: begin
                // source starts at zero, the rest at infinity
                w_dm_we    = 1'b1;
                w_dm_waddr = r_col[VB-1:0];
                w_dm_wdata = (r_col[VB-1:0] == r_src) ? '0 : msps_pkg::DIST_INF;
            end
            msps_pkg::S_RELAX, msps_pkg::S_RELAX_W: begin
                w_req.op     = msps_pkg::OP_RELAX;
                w_req.a      = r_best_d;
                w_req.addend = (DW + 1)'(w_wm_rdata);
                w_req.b      = w_dm_rdata;
                w_dm_we      = w_take;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= msps_pkg::S_IDLE;
            r_vcount <= msps_pkg::VCOUNT_RST;
            r_ovalid <= 1'b0;
            r_rv     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcount <= i_cfg_data;
            end
            // a new beat loads only into a free register, so loading wins
            if ((r_state == msps_pkg::S_OUT_LD)
                    || ((r_state == msps_pkg::S_ERR) && w_out_free)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            // read issued this cycle, data valid next cycle
            r_rv <= (r_state == msps_pkg::S_CHECK) || (r_state == msps_pkg::S_PICK)
                    || (r_state == msps_pkg::S_RELAX);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_ridx <= r_col[VB-1:0];
        unique case (r_state) inside
            msps_pkg::S_IDLE: begin
                r_row <= '0;
                r_col <= '0;
                r_src <= VB'(w_source_vertex);
                r_err <= (w_n == '0) ? msps_pkg::ST_EMPTY : msps_pkg::ST_RANGE;
            end
            msps_pkg::S_CHECK, msps_pkg::S_CHECK_W: begin
                if (w_rd_neg) begin
                    r_err <= msps_pkg::ST_NEG;
                end
                if (r_state == msps_pkg::S_CHECK_W) begin
                    r_col <= '0;
                end else if (w_col_last) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            msps_pkg::S_INIT: begin
                r_col     <= w_col_last ? '0 : r_col + 1'b1;
                r_settled <= '0;
                r_round   <= '0;
                r_best_d  <= msps_pkg::DIST_INF;
                r_best_v  <= '0;
            end
            msps_pkg::S_PICK, msps_pkg::S_PICK_W: begin
                if (r_state == msps_pkg::S_PICK) begin
                    r_col <= w_col_last ? '0 : r_col + 1'b1;
                end
                if (w_take) begin
                    r_best_d <= w_res.sum;
                    r_best_v <= r_ridx;
                end
            end
            msps_pkg::S_DECIDE: begin
                if (r_best_d != msps_pkg::DIST_INF) begin
                    r_settled[r_best_v] <= 1'b1;
                end
            end
            msps_pkg::S_RELAX: begin
                r_col <= w_col_last ? '0 : r_col + 1'b1;
            end
            msps_pkg::S_RELAX_W: begin
                r_round  <= r_round + 1'b1;
                r_best_d <= msps_pkg::DIST_INF;
                r_best_v <= '0;
            end
            msps_pkg::S_OUT_LD: begin
                r_col   <= w_col_last ? '0 : r_col + 1'b1;
                r_ovtx  <= msps_pkg::VTX_OUT_W'(r_col);
                r_odist <= w_dm_rdata;
                r_ostat <= msps_pkg::ST_OK;
                r_olast <= w_col_last;
            end
            msps_pkg::S_ERR: begin
                if (w_out_free) begin
                    r_ovtx  <= '0;
                    r_odist <= '0;
                    r_ostat <= r_err;
                    r_olast <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = msps_pkg::OUT_TDATA_W'({r_odist, r_ovtx});
    assign o_m_tuser  = r_ostat;
    assign o_m_tlast  = r_olast;

    // a result is only loaded into a free output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msps_pkg::S_OUT_LD) |-> !r_ovalid)
        else $error("result loaded over a pending beat");

    // a finite pick always names an unsettled vertex
    a_pick_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == msps_pkg::S_DECIDE) && (r_best_d != msps_pkg::DIST_INF))
        |-> !r_settled[r_best_v])
        else $error("picked vertex already settled");

    // no more than count-1 rounds
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msps_pkg::S_DECIDE) |-> ((r_round + 1'b1) < {1'b0, w_n}))
        else $error("round count past vertex count");

    // no input beat taken while the matrix clear is running
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wm_busy |-> !o_s_tready)
        else $error("input beat accepted during matrix clear");

endmodule

`default_nettype wire

### hw/rtl/msps_wmem.sv
// weight matrix memory with clearing pass after reset
`default_nettype none

module msps_wmem #(
    parameter int WEIGHT_BITS = msps_pkg::DEFAULT_WEIGHT_BITS,
    parameter int ADDR_W      = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_we,
    input  wire        [ADDR_W-1:0]      i_waddr,
    input  wire        [WEIGHT_BITS-1:0] i_wdata,
    input  wire        [ADDR_W-1:0]      i_raddr,
    output logic signed [WEIGHT_BITS-1:0] o_rdata,
    output logic                         o_busy
);

    logic [WEIGHT_BITS-1:0] r_mem [0:(1<<ADDR_W)-1];
    logic [ADDR_W-1:0]      r_clr_addr;
    logic                   r_clr_busy;

    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr;
    logic [WEIGHT_BITS-1:0] w_wdata;

    assign w_we    = r_clr_busy | i_we;
    assign w_waddr = r_clr_busy ? r_clr_addr : i_waddr;
    assign w_wdata = r_clr_busy ? '0 : i_wdata;
    assign o_busy  = r_clr_busy;

    // clear sweep, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {ADDR_W{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/msps_dist_mem.sv
// distance memory, one write and one registered read port
`default_nettype none

module msps_dist_mem #(
    parameter int ADDR_W = 4
) (
    input  wire                           i_clk,
    input  wire                           i_we,
    input  wire  [ADDR_W-1:0]             i_waddr,
    input  wire  [msps_pkg::DIST_W-1:0]   i_wdata,
    input  wire  [ADDR_W-1:0]             i_raddr,
    output logic [msps_pkg::DIST_W-1:0]   o_rdata
);

    logic [msps_pkg::DIST_W-1:0] r_mem [0:(1<<ADDR_W)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/msps_alu.sv
// shared add and compare unit for minimum pick and edge relaxation
`default_nettype none

module msps_alu (
    input  wire msps_pkg::t_alu_req i_req,
    output msps_pkg::t_alu_res      o_res
);

    logic [msps_pkg::DIST_W:0] w_sum;
    logic                      w_pos;

    assign w_sum = {1'b0, i_req.a} + $unsigned(i_req.addend);
    assign w_pos = !i_req.addend[msps_pkg::DIST_W] && (i_req.addend != '0);

    always_comb begin
        o_res.sum = w_sum[msps_pkg::DIST_W-1:0];
        case (i_req.op)
            msps_pkg::OP_RELAX: begin
                // skip sums past the infinity code
                o_res.hit = w_pos && !w_sum[msps_pkg::DIST_W]
                            && (w_sum[msps_pkg::DIST_W-1:0] < i_req.b);
            end
            default: begin
                // ties go to the later index
                o_res.hit = (i_req.a <= i_req.b);
            end
        endcase
    end

endmodule

`default_nettype wire
